// ----- design/swk_pkg.sv -----
// Shared types, constants and the arctangent table of the swerve wheel kinematics block.
package swk_pkg;

   localparam int MAX_WHEELS = 4;
   localparam int CW = 40;
   localparam int AW = 26;
   localparam int CORDIC_CELLS = 20;
   localparam int ROOT_CELLS = 32;

   localparam logic [2:0] CSR_COM_X = 3'd0;
   localparam logic [2:0] CSR_COM_Y = 3'd1;
   localparam logic [2:0] CSR_WHEEL_COUNT = 3'd2;
   localparam logic [2:0] CSR_GEOM0 = 3'd3;
   localparam logic [2:0] CSR_GEOM1 = 3'd4;
   localparam logic [2:0] CSR_GEOM2 = 3'd5;
   localparam logic [2:0] CSR_GEOM3 = 3'd6;

   typedef struct packed {
      logic valid;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [AW-1:0] acc;
   } cordic_type;

   typedef struct packed {
      logic valid;
      logic [63:0] rem;
      logic [63:0] root;
   } root_type;

   function automatic logic signed [AW-1:0] atan_val(input logic [4:0] idx);
      logic signed [AW-1:0] v;
      case (idx)
         5'd0: v = 26'sd2097152;
         5'd1: v = 26'sd1238021;
         5'd2: v = 26'sd654136;
         5'd3: v = 26'sd332050;
         5'd4: v = 26'sd166669;
         5'd5: v = 26'sd83416;
         5'd6: v = 26'sd41718;
         5'd7: v = 26'sd20860;
         5'd8: v = 26'sd10430;
         5'd9: v = 26'sd5215;
         5'd10: v = 26'sd2608;
         5'd11: v = 26'sd1304;
         5'd12: v = 26'sd652;
         5'd13: v = 26'sd326;
         5'd14: v = 26'sd163;
         5'd15: v = 26'sd81;
         5'd16: v = 26'sd41;
         5'd17: v = 26'sd20;
         5'd18: v = 26'sd10;
         5'd19: v = 26'sd5;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- design/swk_cordic_cell.sv -----
// One vectoring CORDIC iteration with its own pipeline register.
module swk_cordic_cell (
   input logic clock,
   input logic reset,
   input logic [4:0] stage,
   input swk_pkg::cordic_type din,
   output swk_pkg::cordic_type dout
);
   import swk_pkg::*;

   cordic_type res_in;
   cordic_type res_ff;
   logic signed [CW-1:0] xs;
   logic signed [CW-1:0] ys;

   always_comb begin
      xs = din.x >>> stage;
      ys = din.y >>> stage;
      res_in.valid = din.valid;
      if (!din.y[CW-1]) begin
         res_in.x = din.x + ys;
         res_in.y = din.y - xs;
         res_in.acc = din.acc + atan_val(stage);
      end else begin
         res_in.x = din.x - ys;
         res_in.y = din.y + xs;
         res_in.acc = din.acc - atan_val(stage);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else begin
         res_ff.valid <= res_in.valid;
      end
      res_ff.x <= res_in.x;
      res_ff.y <= res_in.y;
      res_ff.acc <= res_in.acc;
   end

   assign dout = res_ff;
endmodule

// ----- design/swk_root_cell.sv -----
// One bit step of the integer square root with its own pipeline register.
module swk_root_cell (
   input logic clock,
   input logic reset,
   input logic [4:0] stage,
   input swk_pkg::root_type din,
   output swk_pkg::root_type dout
);
   import swk_pkg::*;

   root_type res_in;
   root_type res_ff;
   logic [63:0] bitv;
   logic [64:0] trial;

   always_comb begin
      bitv = 64'd1 << (6'd62 - {stage, 1'b0});
      trial = {1'b0, din.root} + {1'b0, bitv};
      res_in.valid = din.valid;
      if ({1'b0, din.rem} >= trial) begin
         res_in.rem = din.rem - trial[63:0];
         res_in.root = (din.root >> 1) + bitv;
      end else begin
         res_in.rem = din.rem;
         res_in.root = din.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else begin
         res_ff.valid <= res_in.valid;
      end
      res_ff.rem <= res_in.rem;
      res_ff.root <= res_in.root;
   end

   assign dout = res_ff;
endmodule

// ----- design/swerve_wheel_kinematics.sv -----
// Top level of the swerve wheel kinematics block: sequencer, registers and cell chains.
// Each velocity request yields one result per configured wheel, in wheel order, with
// tlast on the final one; a wheel count of zero yields none. The time a wheel takes is set
// mainly by the 32-cell square root chain and by the normalizing shifts ahead of the 20-cell
// CORDIC chain (one bit per cycle, up to 30 bits); wheels are processed one after another,
// and each result is held until it is taken. Requests are taken only when the previous
// request is fully delivered; configuration writes are accepted at any time.
module swerve_wheel_kinematics (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   input logic [47:0] req_tdata,   // lin_x, lin_y, ang_z
   output logic rsp_tvalid,
   input logic rsp_tready,
   output logic [47:0] rsp_tdata,  // wheel identifier, steering angle, spin rate
   output logic rsp_tlast,
   input logic csr_valid,
   output logic csr_ready,
   input logic [2:0] csr_index,
   input logic [55:0] csr_data
);
   import swk_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_MA, S_AA, S_AB, S_PRE, S_SQ, S_NORM, S_GO, S_WAIT, S_MAG, S_FIN, S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic signed [15:0] comx_ff, comy_ff;
   logic [2:0] wcount_ff;
   logic [55:0] geom_ff [MAX_WHEELS];

   logic signed [15:0] vx_ff, vy_ff, wz_ff;
   logic [1:0] k_ff;
   logic [2:0] n_ff;
   logic signed [16:0] dx_ff, dy_ff;
   logic signed [32:0] prod_ff;
   logic signed [33:0] a_ff, b_ff;
   logic [33:0] ua_ff, ub_ff;
   logic [63:0] sum_ff;
   logic [2:0] sq_ff;
   logic signed [CW-1:0] x_ff, y_ff;
   logic signed [AW-1:0] acc_ff;
   logic zero_ff;
   logic signed [17:0] ang_ff;
   logic [31:0] root_ff;
   logic [32:0] mag_ff;
   logic rsp_valid_ff;
   logic [7:0] rid_ff;
   logic [15:0] rang_ff;
   logic [23:0] rspd_ff;
   logic rlast_ff;

   logic [55:0] g;
   logic [2:0] nreq;
   logic signed [CW-1:0] sx, sy, px_in, py_in;
   logic signed [AW-1:0] pacc_in;
   logic [33:0] sq_u;
   logic [2:0] sq_j;
   logic [33:0] sq_p;
   logic [63:0] sq_term;
   logic big;
   logic signed [17:0] fang;
   logic signed [34:0] fspd;
   logic [47:0] mag_wide;

   cordic_type c_link [CORDIC_CELLS+1];
   root_type r_link [ROOT_CELLS+1];

   assign g = geom_ff[k_ff];
   assign nreq = (wcount_ff > 3'(MAX_WHEELS)) ? 3'(MAX_WHEELS) : wcount_ff;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      sx = wz_ff[15] ? -CW'(b_ff) : CW'(b_ff);
      sy = wz_ff[15] ? -CW'(a_ff) : CW'(a_ff);
      px_in = sx;
      py_in = sy;
      pacc_in = '0;
      if (sx[CW-1]) begin
         if (!sy[CW-1]) begin
            px_in = sy;
            py_in = -sx;
            pacc_in = AW'(24'sd4194304);
         end else begin
            px_in = -sy;
            py_in = sx;
            pacc_in = -AW'(24'sd4194304);
         end
      end
   end

   always_comb begin
      sq_u = (sq_ff < 3'd3) ? ua_ff : ub_ff;
      sq_j = (sq_ff < 3'd3) ? sq_ff : sq_ff - 3'd3;
      case (sq_j)
         3'd0: begin
            sq_p = {17'd0, sq_u[16:0]} * {17'd0, sq_u[16:0]};
            sq_term = 64'(sq_p);
         end
         3'd1: begin
            sq_p = {17'd0, sq_u[33:17]} * {17'd0, sq_u[16:0]};
            sq_term = 64'(sq_p) << 18;
         end
         3'd2: begin
            sq_p = {17'd0, sq_u[33:17]} * {17'd0, sq_u[33:17]};
            sq_term = 64'(sq_p) << 34;
         end
         default: begin
            sq_p = '0;
            sq_term = '0;
         end
      endcase
   end

   assign big = (x_ff >= CW'(64'sd1073741824)) || (x_ff <= -CW'(64'sd1073741824)) ||
                (y_ff >= CW'(64'sd1073741824)) || (y_ff <= -CW'(64'sd1073741824));

   assign mag_wide = 48'(root_ff) * 48'(g[47:32]) + 48'd32768;

   always_comb begin
      fang = zero_ff ? 18'sd0 : ang_ff;
      fspd = wz_ff[15] ? -35'(mag_ff) : 35'(mag_ff);
      if (fang > 18'sd16384) begin
         fang = fang - 18'sd32768;
         fspd = -fspd;
      end else if (fang < -18'sd16384) begin
         fang = fang + 18'sd32768;
         fspd = -fspd;
      end
      if (fspd > 35'sd8388607) begin
         fspd = 35'sd8388607;
      end else if (fspd < -35'sd8388608) begin
         fspd = -35'sd8388608;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_tvalid && nreq != 3'd0) state_in = S_LOAD;
         S_LOAD: state_in = S_MA;
         S_MA: state_in = S_AA;
         S_AA: state_in = S_AB;
         S_AB: state_in = S_PRE;
         S_PRE: state_in = S_SQ;
         S_SQ: if (sq_ff == 3'd5) state_in = S_NORM;
         S_NORM: if (zero_ff || big) state_in = S_GO;
         S_GO: state_in = S_WAIT;
         S_WAIT: if (r_link[ROOT_CELLS].valid) state_in = S_MAG;
         S_MAG: state_in = S_FIN;
         S_FIN: state_in = S_OUT;
         S_OUT: begin
            if (rsp_tready) state_in = (3'(k_ff) + 3'd1 == n_ff) ? S_IDLE : S_LOAD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         comx_ff <= '0;
         comy_ff <= '0;
         wcount_ff <= 3'd4;
         for (int i = 0; i < MAX_WHEELS; i++) geom_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_COM_X: comx_ff <= csr_data[15:0];
               CSR_COM_Y: comy_ff <= csr_data[15:0];
               CSR_WHEEL_COUNT: wcount_ff <= csr_data[2:0];
               CSR_GEOM0, CSR_GEOM1, CSR_GEOM2, CSR_GEOM3:
                  geom_ff[2'(csr_index - CSR_GEOM0)] <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == S_FIN) rsp_valid_ff <= 1'b1;
         else if (state_ff == S_OUT && rsp_tready) rsp_valid_ff <= 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            vx_ff <= req_tdata[15:0];
            vy_ff <= req_tdata[31:16];
            wz_ff <= req_tdata[47:32];
            n_ff <= nreq;
            k_ff <= '0;
         end
         S_LOAD: begin
            dx_ff <= 17'(signed'(g[15:0])) - 17'(comx_ff);
            dy_ff <= 17'(comy_ff) - 17'(signed'(g[31:16]));
         end
         S_MA: prod_ff <= 33'(dx_ff) * 33'(wz_ff);
         S_AA: begin
            a_ff <= 34'(prod_ff) + 34'(vy_ff) * 34'sd1000;
            prod_ff <= 33'(dy_ff) * 33'(wz_ff);
         end
         S_AB: b_ff <= 34'(vx_ff) * 34'sd1000 + 34'(prod_ff);
         S_PRE: begin
            ua_ff <= a_ff[33] ? 34'(-a_ff) : 34'(a_ff);
            ub_ff <= b_ff[33] ? 34'(-b_ff) : 34'(b_ff);
            x_ff <= px_in;
            y_ff <= py_in;
            acc_ff <= pacc_in;
            zero_ff <= (a_ff == '0) && (b_ff == '0);
            sum_ff <= '0;
            sq_ff <= '0;
         end
         S_SQ: begin
            sum_ff <= sum_ff + sq_term;
            sq_ff <= sq_ff + 3'd1;
         end
         S_NORM: begin
            if (!(zero_ff || big)) begin
               x_ff <= x_ff <<< 1;
               y_ff <= y_ff <<< 1;
            end
         end
         S_WAIT: begin
            if (c_link[CORDIC_CELLS].valid) begin
               ang_ff <= 18'((c_link[CORDIC_CELLS].acc + AW'(9'sd128)) >>> 8);
            end
            if (r_link[ROOT_CELLS].valid) root_ff <= r_link[ROOT_CELLS].root[31:0];
         end
         S_MAG: mag_ff <= {1'b0, mag_wide[47:16]};
         S_FIN: begin
            rid_ff <= g[55:48];
            rang_ff <= fang[15:0];
            rspd_ff <= fspd[23:0];
            rlast_ff <= (3'(k_ff) + 3'd1 == n_ff);
         end
         S_OUT: if (rsp_tready) k_ff <= k_ff + 2'd1;
         default: ;
      endcase
   end

   assign c_link[0].valid = (state_ff == S_GO);
   assign c_link[0].x = x_ff;
   assign c_link[0].y = y_ff;
   assign c_link[0].acc = acc_ff;

   assign r_link[0].valid = (state_ff == S_GO);
   assign r_link[0].rem = sum_ff;
   assign r_link[0].root = '0;

   for (genvar i = 0; i < CORDIC_CELLS; i++) begin : g_cordic
      swk_cordic_cell u_cell (
         .clock(clock),
         .reset(reset),
         .stage(5'(i)),
         .din(c_link[i]),
         .dout(c_link[i+1])
      );
   end

   for (genvar i = 0; i < ROOT_CELLS; i++) begin : g_root
      swk_root_cell u_cell (
         .clock(clock),
         .reset(reset),
         .stage(5'(i)),
         .din(r_link[i]),
         .dout(r_link[i+1])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {rspd_ff, rang_ff, rid_ff};
   assign rsp_tlast = rlast_ff;
endmodule
